@@ design/dkc_pkg.sv @@
// Shared types and constants for the differential key counter
`timescale 1ns / 1ps

package dkc_pkg;

  // Candidate space: four 4-bit subkey nibbles
  localparam int unsigned KEY_BITS       = 16;
  localparam int unsigned NUM_CANDIDATES = 65536;
  localparam int unsigned CIPHER_BITS    = 32;
  localparam int unsigned REPORT_BITS    = 32;

  // Reset value of the expected-difference register
  localparam logic [15:0] TARGET_RESET = 16'h8484;

  // Item modes
  localparam logic MODE_PAIR   = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  typedef logic [3:0]             nibble_t;
  typedef logic [KEY_BITS-1:0]    key_t;
  typedef logic [CIPHER_BITS-1:0] cipher_t;

  // Inverse S-box of the cipher
  localparam nibble_t INV_SBOX [16] = '{
    4'hd, 4'h0, 4'h8, 4'h6, 4'h2, 4'hc, 4'h4, 4'hb,
    4'he, 4'h7, 4'h1, 4'ha, 4'h3, 4'h9, 4'hf, 4'h5
  };

endpackage

@@ design/dkc_if.sv @@
// Channel interfaces: input items, result items and the config write port
`timescale 1ns / 1ps

interface dkc_in_if;
  logic             valid;
  logic             ready;
  logic             mode;
  dkc_pkg::cipher_t cipher_first;
  dkc_pkg::cipher_t cipher_second;

  modport source (output valid, mode, cipher_first, cipher_second, input ready);
  modport sink   (input valid, mode, cipher_first, cipher_second, output ready);
endinterface

interface dkc_out_if;
  logic                               valid;
  logic                               ready;
  dkc_pkg::key_t                      best_key;
  logic [dkc_pkg::REPORT_BITS-1:0]    best_count;

  modport source (output valid, best_key, best_count, input ready);
  modport sink   (input valid, best_key, best_count, output ready);
endinterface

interface dkc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] target_diff;

  modport source (output valid, target_diff, input ready);
  modport sink   (input valid, target_diff, output ready);
endinterface

@@ design/dkc_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module dkc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/differential_key_counter_core.sv @@
// Top level: last-round subkey candidate counter with one counter RAM
// Reset: rst starts a clearing pass that zeroes every entry of the counter RAM;
//   no item is taken during it, config writes are taken throughout it.
// Pair item: sweeps every candidate key, one counter read-modify-write per cycle;
//   a pair that fails the nibble filter is dropped without a sweep.
// Report item: sweep, drain, then hold loads the result; items are taken again once it is valid.
// One item at a time; the counter RAM port sets the pace.
`timescale 1ns / 1ps

module differential_key_counter_core #(
  parameter int COUNTER_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  dkc_in_if.sink    items,
  dkc_out_if.source results,
  dkc_cfg_if.sink   cfg
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_HOLD
  } state_t;

  state_t                   state;
  dkc_pkg::key_t            idx;
  logic                     op_report;
  dkc_pkg::nibble_t         a_nib [4];
  dkc_pkg::nibble_t         b_nib [4];
  logic [15:0]              target_diff;

  // read stage
  logic                     rd_valid;
  dkc_pkg::key_t            rd_key;
  logic                     rd_hit;
  logic [COUNTER_BITS-1:0]  rd_data;

  // running best
  dkc_pkg::key_t            best_key_q;
  logic [COUNTER_BITS-1:0]  best_count_q;

  // output register
  logic                             out_valid;
  dkc_pkg::key_t                    out_key;
  logic [dkc_pkg::REPORT_BITS-1:0]  out_count;

  logic                     issue_hit;
  logic                     pair_pass;
  logic                     wr_en;
  dkc_pkg::key_t            wr_addr;
  logic [COUNTER_BITS-1:0]  wr_data;
  logic                     rd_en;

  // Config register, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_diff <= dkc_pkg::TARGET_RESET;
    end else if (cfg.valid) begin
      target_diff <= cfg.target_diff;
    end
  end

  // Nibbles 1, 3, 5, 7 must match for a pair to count
  assign pair_pass = (items.cipher_first[27:24] == items.cipher_second[27:24]) &&
                     (items.cipher_first[19:16] == items.cipher_second[19:16]) &&
                     (items.cipher_first[11:8]  == items.cipher_second[11:8])  &&
                     (items.cipher_first[3:0]   == items.cipher_second[3:0]);

  // Candidate test for the key being issued to the RAM
  always_comb begin
    issue_hit = 1'b1;
    for (int s = 0; s < 4; s++) begin
      if ((dkc_pkg::INV_SBOX[idx[15-4*s -: 4] ^ a_nib[s]] ^
           dkc_pkg::INV_SBOX[idx[15-4*s -: 4] ^ b_nib[s]]) != target_diff[15-4*s -: 4]) begin
        issue_hit = 1'b0;
      end
    end
  end

  // Counter RAM access: clear pass, or saturating increment written back
  always_comb begin
    rd_en = (state == S_SWEEP);
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = idx;
      wr_data = '0;
    end else begin
      wr_en   = rd_valid && !op_report && rd_hit && !(&rd_data);
      wr_addr = rd_key;
      wr_data = rd_data + 1'b1;
    end
  end

  dkc_ram #(
    .WIDTH (COUNTER_BITS),
    .DEPTH (dkc_pkg::NUM_CANDIDATES)
  ) u_counts (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  assign items.ready        = (state == S_IDLE);
  assign results.valid      = out_valid;
  assign results.best_key   = out_key;
  assign results.best_count = out_count;

  // Sequencer, read stage, running best and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= (state == S_SWEEP);
      rd_key   <= idx;
      rd_hit   <= issue_hit;

      // the hold state reloads the output register itself
      if (out_valid && results.ready && state != S_HOLD) begin
        out_valid <= 1'b0;
      end

      // strict compare keeps the lowest index on ties
      if (rd_valid && op_report && (rd_data > best_count_q)) begin
        best_count_q <= rd_data;
        best_key_q   <= rd_key;
      end

      case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (&idx) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (items.valid) begin
            op_report    <= (items.mode == dkc_pkg::MODE_REPORT);
            best_key_q   <= '0;
            best_count_q <= '0;
            idx          <= '0;
            for (int s = 0; s < 4; s++) begin
              a_nib[s] <= items.cipher_first[31-8*s -: 4];
              b_nib[s] <= items.cipher_second[31-8*s -: 4];
            end
            if (items.mode == dkc_pkg::MODE_REPORT || pair_pass) begin
              state <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          idx <= idx + 1'b1;
          if (&idx) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= op_report ? S_HOLD : S_IDLE;
        end
        S_HOLD: begin
          if (!out_valid || results.ready) begin
            out_valid <= 1'b1;
            out_key   <= best_key_q;
            out_count <= dkc_pkg::REPORT_BITS'(best_count_q);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // A read result only follows a sweep cycle
  a_rd_after_sweep: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(state == S_SWEEP))
    else $error("read stage valid without a sweep issue");

  // No item taken while a read-modify-write is still in flight
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    items.ready |-> !rd_valid)
    else $error("item accepted with a pending counter update");

  // The clearing pass blocks items
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !items.ready)
    else $error("item ready during clearing pass");

  // Running best never decreases during a report sweep
  a_best_monotonic: assert property (@(posedge clk) disable iff (rst)
    (rd_valid && op_report) |=> (best_count_q >= $past(best_count_q)))
    else $error("running best count decreased");

  // Counter writes only increment by one over the read value
  a_wr_increment: assert property (@(posedge clk) disable iff (rst)
    (wr_en && state != S_CLEAR) |-> (wr_data == rd_data + 1'b1) && !(&rd_data))
    else $error("counter write is not a saturating increment");
`endif

endmodule
